@@ src/psd_pkg.sv @@
// Shared types and constants for the point-to-segment squared distance pipeline.
// No dependencies; every other file imports this package.
package psd_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int RATIO_FRAC_BITS = 16;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int LEN2_W  = SQ_W + 1;
    localparam int DOT_W   = SQ_W + 2;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int QUO_W   = RATIO_FRAC_BITS + 1;
    localparam int T_W     = RATIO_FRAC_BITS + 1;
    localparam int SCALE_W = COORD_WIDTH + T_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam int S_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;

    localparam logic [T_W-1:0]     RATIO_UNITY = T_W'(1) << RATIO_FRAC_BITS;
    localparam logic [SCALE_W-1:0] ROUND_HALF  = SCALE_W'(1) << (RATIO_FRAC_BITS - 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef enum logic [1:0] {
        RATIO_ZERO = 2'd0,
        RATIO_ONE  = 2'd1,
        RATIO_DIV  = 2'd2
    } ratio_kind_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t sx;
        coord_t sy;
        diff_t  dx;
        diff_t  dy;
    } geom_t;

    typedef struct packed {
        geom_t             geom;
        logic [LEN2_W-1:0] len2;
        logic [LEN2_W-1:0] rem;
        ratio_kind_t       kind;
    } front_out_t;

    typedef struct packed {
        geom_t            geom;
        logic [QUO_W-1:0] quo;
        ratio_kind_t      kind;
    } div_out_t;

endpackage

@@ src/psd_front.sv @@
// Front end: segment and offset vectors, products, dot product and squared length,
// then ratio classification. Four register stages. Depends on psd_pkg.
module psd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  psd_pkg::coord_t       point_x,
    input  psd_pkg::coord_t       point_y,
    input  psd_pkg::coord_t       seg_start_x,
    input  psd_pkg::coord_t       seg_start_y,
    input  psd_pkg::coord_t       seg_end_x,
    input  psd_pkg::coord_t       seg_end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output psd_pkg::front_out_t   out_data
);
    import psd_pkg::*;

    localparam int NSTAGE = 4;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    geom_t             geom1_reg, geom1_next;
    diff_t             fx1_reg, fx1_next;
    diff_t             fy1_reg, fy1_next;

    geom_t             geom2_reg;
    logic [SQ_W-1:0]   sqx2_reg, sqx2_next;
    logic [SQ_W-1:0]   sqy2_reg, sqy2_next;
    prod_t             pdx2_reg, pdx2_next;
    prod_t             pdy2_reg, pdy2_next;

    geom_t             geom3_reg;
    logic [LEN2_W-1:0] len2_3_reg, len2_3_next;
    logic signed [DOT_W-1:0] dot3_reg, dot3_next;

    front_out_t        out_reg, out_next;

    prod_t             sqx_full, sqy_full;

    // ready ripples back from the output; a stage moves when empty or drained
    assign adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
    genvar g;
    generate
        for (g = 0; g < NSTAGE - 1; g++) begin : g_adv
            assign adv[g] = !valid_reg[g] || adv[g+1];
        end
    endgenerate

    assign in_ready   = adv[0];
    assign valid_next = {valid_reg[NSTAGE-2:0], in_valid};

    always_comb begin
        geom1_next.px = point_x;
        geom1_next.py = point_y;
        geom1_next.sx = seg_start_x;
        geom1_next.sy = seg_start_y;
        geom1_next.dx = DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
        geom1_next.dy = DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
        fx1_next      = DIFF_W'(point_x) - DIFF_W'(seg_start_x);
        fy1_next      = DIFF_W'(point_y) - DIFF_W'(seg_start_y);
    end

    always_comb begin
        sqx_full  = $signed(geom1_reg.dx) * $signed(geom1_reg.dx);
        sqy_full  = $signed(geom1_reg.dy) * $signed(geom1_reg.dy);
        sqx2_next = sqx_full[SQ_W-1:0];
        sqy2_next = sqy_full[SQ_W-1:0];
        pdx2_next = $signed(fx1_reg) * $signed(geom1_reg.dx);
        pdy2_next = $signed(fy1_reg) * $signed(geom1_reg.dy);
    end

    always_comb begin
        len2_3_next = LEN2_W'(sqx2_reg) + LEN2_W'(sqy2_reg);
        dot3_next   = DOT_W'(pdx2_reg) + DOT_W'(pdy2_reg);
    end

    // clamp cases settle here; only the open interval uses the divider quotient
    always_comb begin
        out_next.geom = geom3_reg;
        out_next.len2 = len2_3_reg;
        out_next.rem  = dot3_reg[LEN2_W-1:0];
        if (len2_3_reg == '0 || dot3_reg[DOT_W-1] || dot3_reg == '0) begin
            out_next.kind = RATIO_ZERO;
        end else if (dot3_reg[LEN2_W-1:0] >= len2_3_reg) begin
            out_next.kind = RATIO_ONE;
        end else begin
            out_next.kind = RATIO_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            geom1_reg <= geom1_next;
            fx1_reg   <= fx1_next;
            fy1_reg   <= fy1_next;
        end
        if (adv[1]) begin
            geom2_reg <= geom1_reg;
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
            pdx2_reg  <= pdx2_next;
            pdy2_reg  <= pdy2_next;
        end
        if (adv[2]) begin
            geom3_reg  <= geom2_reg;
            len2_3_reg <= len2_3_next;
            dot3_reg   <= dot3_next;
        end
        if (adv[3]) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign out_data  = out_reg;

endmodule

@@ src/psd_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, dot / len2 to
// RATIO_FRAC_BITS+1 fraction bits. Depends on psd_pkg.
module psd_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  psd_pkg::front_out_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output psd_pkg::div_out_t     out_data
);
    import psd_pkg::*;

    typedef struct packed {
        geom_t             geom;
        logic [LEN2_W-1:0] len2;
        logic [LEN2_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        ratio_kind_t       kind;
    } div_stage_t;

    logic [QUO_W-1:0] valid_reg;
    logic [QUO_W-1:0] valid_next;
    logic [QUO_W-1:0] adv;

    div_stage_t stage_reg  [QUO_W];
    div_stage_t stage_next [QUO_W];
    div_stage_t stage_in   [QUO_W];

    assign adv[QUO_W-1] = !valid_reg[QUO_W-1] || out_ready;
    assign in_ready     = adv[0];
    assign valid_next   = {valid_reg[QUO_W-2:0], in_valid};

    assign stage_in[0].geom = in_data.geom;
    assign stage_in[0].len2 = in_data.len2;
    assign stage_in[0].rem  = in_data.rem;
    assign stage_in[0].quo  = '0;
    assign stage_in[0].kind = in_data.kind;

    genvar g;
    generate
        for (g = 0; g < QUO_W - 1; g++) begin : g_link
            assign adv[g]        = !valid_reg[g] || adv[g+1];
            assign stage_in[g+1] = stage_reg[g];
        end

        for (g = 0; g < QUO_W; g++) begin : g_step
            logic [LEN2_W:0] shifted;
            logic [LEN2_W:0] trial;
            logic            ge;

            assign shifted = {stage_in[g].rem, 1'b0};
            assign trial   = shifted - {1'b0, stage_in[g].len2};
            assign ge      = shifted >= {1'b0, stage_in[g].len2};

            always_comb begin
                stage_next[g]     = stage_in[g];
                stage_next[g].rem = ge ? trial[LEN2_W-1:0] : shifted[LEN2_W-1:0];
                stage_next[g].quo = {stage_in[g].quo[QUO_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (adv[g]) begin
                    valid_reg[g] <= valid_next[g];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv[g]) begin
                    stage_reg[g] <= stage_next[g];
                end
            end

            // partial remainder stays below the divisor for a dividing item
            a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
                valid_reg[g] && stage_reg[g].kind == RATIO_DIV
                |-> stage_reg[g].rem < stage_reg[g].len2)
                else $error("divider remainder not below divisor");
        end
    endgenerate

    assign out_valid     = valid_reg[QUO_W-1];
    assign out_data.geom = stage_reg[QUO_W-1].geom;
    assign out_data.quo  = stage_reg[QUO_W-1].quo;
    assign out_data.kind = stage_reg[QUO_W-1].kind;

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[QUO_W-1] && !out_ready
        |=> valid_reg[QUO_W-1] && $stable(stage_reg[QUO_W-1].quo))
        else $error("divider output changed while stalled");

endmodule

@@ src/psd_back.sv @@
// Back end: ratio rounding, projection onto the segment, error vector and
// squared distance. Five register stages, the last is the output register. Depends on psd_pkg.
module psd_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  psd_pkg::div_out_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [psd_pkg::DIST_W-1:0] dist_squared
);
    import psd_pkg::*;

    localparam int NSTAGE = 5;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t sx;
        coord_t sy;
    } anchor_t;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    anchor_t                 anc1_reg, anc1_next;
    logic                    negx1_reg, negx1_next;
    logic                    negy1_reg, negy1_next;
    logic [COORD_WIDTH-1:0]  magx1_reg, magx1_next;
    logic [COORD_WIDTH-1:0]  magy1_reg, magy1_next;
    logic [T_W-1:0]          t1_reg, t1_next;

    anchor_t                 anc2_reg;
    logic                    negx2_reg, negy2_reg;
    logic [SCALE_W-1:0]      scx2_reg, scx2_next;
    logic [SCALE_W-1:0]      scy2_reg, scy2_next;

    diff_t                   errx3_reg, errx3_next;
    diff_t                   erry3_reg, erry3_next;

    logic [SQ_W-1:0]         sqx4_reg, sqx4_next;
    logic [SQ_W-1:0]         sqy4_reg, sqy4_next;

    logic [DIST_W-1:0]       dist5_reg, dist5_next;

    logic [QUO_W:0]          quo_inc;
    diff_t                   absx, absy;
    logic [SCALE_W-1:0]      rndx, rndy;
    logic [COORD_WIDTH-1:0]  rx, ry;
    logic signed [DIFF_W:0]  basex, basey, offx, offy, ox, oy;
    prod_t                   sqx_full, sqy_full;

    assign adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
    genvar g;
    generate
        for (g = 0; g < NSTAGE - 1; g++) begin : g_adv
            assign adv[g] = !valid_reg[g] || adv[g+1];
        end
    endgenerate

    assign in_ready   = adv[0];
    assign valid_next = {valid_reg[NSTAGE-2:0], in_valid};

    // ratio: round the extra quotient bit half up, or take the clamp value
    always_comb begin
        anc1_next.px = in_data.geom.px;
        anc1_next.py = in_data.geom.py;
        anc1_next.sx = in_data.geom.sx;
        anc1_next.sy = in_data.geom.sy;
        quo_inc      = (QUO_W+1)'(in_data.quo) + (QUO_W+1)'(1);
        case (in_data.kind)
            RATIO_ZERO: t1_next = '0;
            RATIO_ONE:  t1_next = RATIO_UNITY;
            RATIO_DIV:  t1_next = quo_inc[QUO_W:1];
            default:    t1_next = '0;
        endcase
        negx1_next = in_data.geom.dx[DIFF_W-1];
        negy1_next = in_data.geom.dy[DIFF_W-1];
        absx       = negx1_next ? -in_data.geom.dx : in_data.geom.dx;
        absy       = negy1_next ? -in_data.geom.dy : in_data.geom.dy;
        magx1_next = absx[COORD_WIDTH-1:0];
        magy1_next = absy[COORD_WIDTH-1:0];
    end

    always_comb begin
        scx2_next = SCALE_W'(magx1_reg) * SCALE_W'(t1_reg);
        scy2_next = SCALE_W'(magy1_reg) * SCALE_W'(t1_reg);
    end

    // magnitude rounded half up gives ties away from zero once the sign returns
    always_comb begin
        rndx  = scx2_reg + ROUND_HALF;
        rndy  = scy2_reg + ROUND_HALF;
        rx    = rndx[RATIO_FRAC_BITS +: COORD_WIDTH];
        ry    = rndy[RATIO_FRAC_BITS +: COORD_WIDTH];
        basex = (DIFF_W+1)'(anc2_reg.px) - (DIFF_W+1)'(anc2_reg.sx);
        basey = (DIFF_W+1)'(anc2_reg.py) - (DIFF_W+1)'(anc2_reg.sy);
        offx  = $signed((DIFF_W+1)'(rx));
        offy  = $signed((DIFF_W+1)'(ry));
        ox    = negx2_reg ? basex + offx : basex - offx;
        oy    = negy2_reg ? basey + offy : basey - offy;
        errx3_next = ox[DIFF_W-1:0];
        erry3_next = oy[DIFF_W-1:0];
    end

    always_comb begin
        sqx_full  = $signed(errx3_reg) * $signed(errx3_reg);
        sqy_full  = $signed(erry3_reg) * $signed(erry3_reg);
        sqx4_next = sqx_full[SQ_W-1:0];
        sqy4_next = sqy_full[SQ_W-1:0];
    end

    assign dist5_next = DIST_W'(sqx4_reg) + DIST_W'(sqy4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            anc1_reg  <= anc1_next;
            negx1_reg <= negx1_next;
            negy1_reg <= negy1_next;
            magx1_reg <= magx1_next;
            magy1_reg <= magy1_next;
            t1_reg    <= t1_next;
        end
        if (adv[1]) begin
            anc2_reg  <= anc1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            scx2_reg  <= scx2_next;
            scy2_reg  <= scy2_next;
        end
        if (adv[2]) begin
            errx3_reg <= errx3_next;
            erry3_reg <= erry3_next;
        end
        if (adv[3]) begin
            sqx4_reg <= sqx4_next;
            sqy4_reg <= sqy4_next;
        end
        if (adv[4]) begin
            dist5_reg <= dist5_next;
        end
    end

    assign out_valid    = valid_reg[NSTAGE-1];
    assign dist_squared = dist5_reg;

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> t1_reg <= RATIO_UNITY)
        else $error("projection ratio above one");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NSTAGE-1] && !out_ready
        |=> valid_reg[NSTAGE-1] && $stable(dist5_reg))
        else $error("result changed while stalled");

endmodule

@@ src/point_segment_distance_squared.sv @@
// Squared distance from a point to a 2-D segment, streaming in and out.
// It has 4 front, 17 divider and 5 back stages. Throughput: one item per cycle
// unless m_tready stalls; every stage is registered, the divider retires one quotient
// bit per stage, and a stage refills as soon as its item moves on.
// Reset: synchronous active-low aresetn clears all stage valid bits; data is not reset.
// Depends on psd_pkg, psd_front, psd_div and psd_back.
module point_segment_distance_squared (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  logic [psd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // dist_squared, zero pad
    output logic [psd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import psd_pkg::*;

    logic              front_valid, front_ready;
    front_out_t        front_data;
    logic              div_valid, div_ready;
    div_out_t          div_data;
    logic [DIST_W-1:0] dist_squared;

    psd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .point_x     (s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .point_y     (s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .seg_start_x (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .seg_start_y (s_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
        .seg_end_x   (s_tdata[4*COORD_WIDTH +: COORD_WIDTH]),
        .seg_end_y   (s_tdata[5*COORD_WIDTH +: COORD_WIDTH]),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_data    (front_data)
    );

    psd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    psd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (div_valid),
        .in_ready     (div_ready),
        .in_data      (div_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .dist_squared (dist_squared)
    );

    assign m_tdata = M_TDATA_W'(dist_squared);

endmodule
